@@ design/ceat_pkg.sv @@
// Package for the compressed-sparse-row edge attribute table.
// Holds the field widths, table sizes, command and status codes and the sequencer states.
// It has no dependencies of its own.
`timescale 1ns / 1ps

package ceat_pkg;

   localparam int MAX_NODES   = 256;
   localparam int MAX_EDGES   = 1024;
   localparam int NODE_W      = 8;
   localparam int EDGE_AW     = 10;
   localparam int CNT_W       = 11;
   localparam int NC_W        = 9;
   localparam int WGT_W       = 32;
   localparam int LAP_W       = 16;
   localparam int CMD_W       = 3;
   localparam int STS_W       = 2;
   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 48;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD       = 3'd0,
      CMD_BUILD      = 3'd1,
      CMD_GET_W_ID   = 3'd2,
      CMD_SET_W_ID   = 3'd3,
      CMD_GET_W_PAIR = 3'd4,
      CMD_SET_W_PAIR = 3'd5,
      CMD_SET_LAP    = 3'd6,
      CMD_GET_LAP    = 3'd7
   } cmd_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK      = 2'd0,
      STS_RANGE   = 2'd1,
      STS_MISSING = 2'd2,
      STS_FULL    = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ACCESS,
      ST_RD_WAIT,
      ST_BLD_RD,
      ST_BLD_CHK,
      ST_ROW_LO,
      ST_ROW_HI,
      ST_SCAN_SET,
      ST_SCAN,
      ST_DIAG_RD,
      ST_RESP
   } state_type;

endpackage

@@ design/csr_edge_attribute_table.sv @@
// Top level of the compressed-sparse-row edge attribute table.
// Depends on ceat_pkg and instantiates ceat_ram for every store.
//
// Usage. Commands arrive as words on the req_ stream, the command code in req_tuser.
// Every command gives exactly one word on the rsp_ stream, the status in rsp_tuser.
// The user writes the node count through csr_wr_en and csr_wr_data only while the
// block is idle; the block itself does not enforce it. One command is handled at a
// time: req_tready is high only while the block is idle. Errors found at decode and
// diagonal index writes go from decode straight to the result word; loads and writes
// by id pass through the access state, the diagonal index read through the diagonal
// read state, and reads by id through the access and read-wait states. Pair commands
// read the two row bounds and then scan the row one edge per cycle; a found edge then
// goes through the access state, and also the read-wait state for reads, while a
// missing one gives the missing status. The build command walks the loaded edges
// through the source store and writes the end of each of the 256 row slots to the
// row store. The result word is held in an output register until rsp_tready is seen;
// the block returns to idle in the cycle after that. Reset empties the table and
// clears the node count; there is no clearing pass, since a load writes zero weight
// and index and the diagonal store has valid bits.
`timescale 1ns / 1ps

module csr_edge_attribute_table (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata: src_node[7:0], dst_node[15:8], edge_id[25:16], weight_in[57:26],
   // lap_index_in[73:58], zero[79:74].
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ceat_pkg::REQ_TDATA_W-1:0] req_tdata,
   // req_tuser: cmd[2:0].
   input  logic [ceat_pkg::CMD_W-1:0]       req_tuser,
   // rsp_tdata: weight_out[31:0], lap_index_out[47:32].
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ceat_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // rsp_tuser: status[1:0].
   output logic [ceat_pkg::STS_W-1:0]       rsp_tuser,
   input  logic                             csr_wr_en,
   input  logic [ceat_pkg::NC_W-1:0]        csr_wr_data
);

   import ceat_pkg::*;

   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [NODE_W-1:0]    u_ff, u_in;
   logic [NODE_W-1:0]    v_ff, v_in;
   logic [EDGE_AW-1:0]   id_ff, id_in;
   logic [WGT_W-1:0]     w_ff, w_in;
   logic [LAP_W-1:0]     li_ff, li_in;
   logic [NC_W-1:0]      nc_ff;
   logic [CNT_W-1:0]     loaded_ff, loaded_in;
   logic                 built_ff, built_in;
   logic [MAX_NODES-1:0] dvalid_ff, dvalid_in;
   logic [EDGE_AW-1:0]   addr_ff, addr_in;
   logic [CNT_W-1:0]     cur_ff, cur_in;
   logic [NODE_W-1:0]    k_ff, k_in;
   logic [CNT_W-1:0]     lo_ff, lo_in;
   logic [CNT_W-1:0]     hi_ff, hi_in;
   logic [CNT_W-1:0]     scan_ff, scan_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic [EDGE_AW-1:0]   chk_pos_ff, chk_pos_in;
   status_type           sts_ff, sts_in;
   logic [WGT_W-1:0]     wout_ff, wout_in;
   logic [LAP_W-1:0]     lout_ff, lout_in;

   logic [NC_W-1:0]      n_use;
   logic                 take;
   logic                 issue;
   logic                 pair_bad;

   logic [NODE_W-1:0]    src_rdata, tgt_rdata;
   logic [WGT_W-1:0]     wgt_rdata, wgt_wdata;
   logic [LAP_W-1:0]     lap_rdata, lap_wdata, diag_rdata;
   logic [CNT_W-1:0]     row_rdata;
   logic [NODE_W-1:0]    row_raddr;
   logic                 edge_we, wgt_we, lap_we, row_we, diag_we;

   assign n_use    = (nc_ff > NC_W'(MAX_NODES)) ? NC_W'(MAX_NODES) : nc_ff;
   assign take     = ({1'b0, k_ff} < n_use) && (cur_ff < loaded_ff) && (src_rdata == k_ff);
   assign issue    = scan_ff < hi_ff;
   assign pair_bad = ({1'b0, u_ff} >= n_use) || ({1'b0, v_ff} >= n_use);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RESP);
   assign rsp_tdata  = {lout_ff, wout_ff};
   assign rsp_tuser  = sts_ff;
   assign row_raddr  = (state_ff == ST_ROW_LO) ? NODE_W'(u_ff - NODE_W'(1)) : u_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         nc_ff     <= '0;
         loaded_ff <= '0;
         built_ff  <= 1'b0;
         dvalid_ff <= '0;
      end else begin
         state_ff  <= state_in;
         loaded_ff <= loaded_in;
         built_ff  <= built_in;
         dvalid_ff <= dvalid_in;
         if (csr_wr_en) begin
            nc_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      u_ff       <= u_in;
      v_ff       <= v_in;
      id_ff      <= id_in;
      w_ff       <= w_in;
      li_ff      <= li_in;
      addr_ff    <= addr_in;
      cur_ff     <= cur_in;
      k_ff       <= k_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      scan_ff    <= scan_in;
      chk_vld_ff <= chk_vld_in;
      chk_pos_ff <= chk_pos_in;
      sts_ff     <= sts_in;
      wout_ff    <= wout_in;
      lout_ff    <= lout_in;
   end

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      u_in       = u_ff;
      v_in       = v_ff;
      id_in      = id_ff;
      w_in       = w_ff;
      li_in      = li_ff;
      loaded_in  = loaded_ff;
      built_in   = built_ff;
      dvalid_in  = dvalid_ff;
      addr_in    = addr_ff;
      cur_in     = cur_ff;
      k_in       = k_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      scan_in    = scan_ff;
      chk_vld_in = chk_vld_ff;
      chk_pos_in = chk_pos_ff;
      sts_in     = sts_ff;
      wout_in    = wout_ff;
      lout_in    = lout_ff;
      edge_we    = 1'b0;
      wgt_we     = 1'b0;
      lap_we     = 1'b0;
      row_we     = 1'b0;
      diag_we    = 1'b0;
      wgt_wdata  = w_ff;
      lap_wdata  = li_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = cmd_type'(req_tuser);
               u_in     = req_tdata[7:0];
               v_in     = req_tdata[15:8];
               id_in    = req_tdata[25:16];
               w_in     = req_tdata[57:26];
               li_in    = req_tdata[73:58];
               sts_in   = STS_OK;
               wout_in  = '0;
               lout_in  = '0;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (cmd_ff)
               CMD_LOAD: begin
                  if (loaded_ff == CNT_W'(MAX_EDGES)) begin
                     sts_in   = STS_FULL;
                     state_in = ST_RESP;
                  end else begin
                     addr_in  = loaded_ff[EDGE_AW-1:0];
                     state_in = ST_ACCESS;
                  end
               end
               CMD_BUILD: begin
                  cur_in   = '0;
                  k_in     = '0;
                  state_in = ST_BLD_RD;
               end
               CMD_GET_W_ID, CMD_SET_W_ID: begin
                  if ({1'b0, id_ff} >= loaded_ff) begin
                     sts_in   = STS_RANGE;
                     state_in = ST_RESP;
                  end else begin
                     addr_in  = id_ff;
                     state_in = ST_ACCESS;
                  end
               end
               default: begin
                  if (pair_bad) begin
                     sts_in   = STS_RANGE;
                     state_in = ST_RESP;
                  end else if (u_ff == v_ff && cmd_ff == CMD_SET_LAP) begin
                     diag_we         = 1'b1;
                     dvalid_in[u_ff] = 1'b1;
                     state_in        = ST_RESP;
                  end else if (u_ff == v_ff && cmd_ff == CMD_GET_LAP) begin
                     state_in = ST_DIAG_RD;
                  end else begin
                     state_in = ST_ROW_LO;
                  end
               end
            endcase
         end
         ST_DIAG_RD: begin
            lout_in  = dvalid_ff[u_ff] ? diag_rdata : '0;
            state_in = ST_RESP;
         end
         ST_BLD_RD: begin
            state_in = ST_BLD_CHK;
         end
         ST_BLD_CHK: begin
            if (take) begin
               cur_in   = CNT_W'(cur_ff + CNT_W'(1));
               state_in = ST_BLD_RD;
            end else begin
               row_we = 1'b1;
               if (k_ff == NODE_W'(MAX_NODES - 1)) begin
                  built_in = 1'b1;
                  state_in = ST_RESP;
               end else begin
                  k_in = NODE_W'(k_ff + NODE_W'(1));
               end
            end
         end
         ST_ROW_LO: begin
            state_in = ST_ROW_HI;
         end
         ST_ROW_HI: begin
            lo_in    = (u_ff == '0 || !built_ff) ? '0 : row_rdata;
            state_in = ST_SCAN_SET;
         end
         ST_SCAN_SET: begin
            hi_in      = built_ff ? row_rdata : '0;
            scan_in    = lo_ff;
            chk_vld_in = 1'b0;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            if (chk_vld_ff && tgt_rdata == v_ff) begin
               addr_in  = chk_pos_ff;
               state_in = ST_ACCESS;
            end else if (!issue && !chk_vld_ff) begin
               sts_in   = STS_MISSING;
               state_in = ST_RESP;
            end else begin
               scan_in    = issue ? CNT_W'(scan_ff + CNT_W'(1)) : scan_ff;
               chk_vld_in = issue;
               chk_pos_in = scan_ff[EDGE_AW-1:0];
            end
         end
         ST_ACCESS: begin
            case (cmd_ff)
               CMD_LOAD: begin
                  edge_we   = 1'b1;
                  wgt_we    = 1'b1;
                  lap_we    = 1'b1;
                  wgt_wdata = '0;
                  lap_wdata = '0;
                  loaded_in = CNT_W'(loaded_ff + CNT_W'(1));
                  state_in  = ST_RESP;
               end
               CMD_SET_W_ID, CMD_SET_W_PAIR: begin
                  wgt_we   = 1'b1;
                  state_in = ST_RESP;
               end
               CMD_SET_LAP: begin
                  lap_we   = 1'b1;
                  state_in = ST_RESP;
               end
               CMD_GET_W_ID, CMD_GET_W_PAIR, CMD_GET_LAP: begin
                  state_in = ST_RD_WAIT;
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end
         ST_RD_WAIT: begin
            if (cmd_ff == CMD_GET_LAP) begin
               lout_in = lap_rdata;
            end else begin
               wout_in = wgt_rdata;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   ceat_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_src_ram (
      .clock   (clock),
      .wr_en   (edge_we),
      .wr_addr (addr_ff),
      .wr_data (u_ff),
      .rd_addr (cur_ff[EDGE_AW-1:0]),
      .rd_data (src_rdata)
   );

   ceat_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_tgt_ram (
      .clock   (clock),
      .wr_en   (edge_we),
      .wr_addr (addr_ff),
      .wr_data (v_ff),
      .rd_addr (scan_ff[EDGE_AW-1:0]),
      .rd_data (tgt_rdata)
   );

   ceat_ram #(.WIDTH(WGT_W), .DEPTH(MAX_EDGES)) u_wgt_ram (
      .clock   (clock),
      .wr_en   (wgt_we),
      .wr_addr (addr_ff),
      .wr_data (wgt_wdata),
      .rd_addr (addr_ff),
      .rd_data (wgt_rdata)
   );

   ceat_ram #(.WIDTH(LAP_W), .DEPTH(MAX_EDGES)) u_lap_ram (
      .clock   (clock),
      .wr_en   (lap_we),
      .wr_addr (addr_ff),
      .wr_data (lap_wdata),
      .rd_addr (addr_ff),
      .rd_data (lap_rdata)
   );

   // Entry k holds the end of row k, which is also the start of row k plus one.
   ceat_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES)) u_row_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (k_ff),
      .wr_data (cur_ff),
      .rd_addr (row_raddr),
      .rd_data (row_rdata)
   );

   ceat_ram #(.WIDTH(LAP_W), .DEPTH(MAX_NODES)) u_diag_ram (
      .clock   (clock),
      .wr_en   (diag_we),
      .wr_addr (u_ff),
      .wr_data (li_ff),
      .rd_addr (u_ff),
      .rd_data (diag_rdata)
   );

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("Input accepted while a result word is pending.");

   a_loaded_bound: assert property (@(posedge clock) disable iff (reset)
      loaded_ff <= CNT_W'(MAX_EDGES))
      else $error("Edge count exceeds the table size.");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == STS_FULL) |-> (loaded_ff == CNT_W'(MAX_EDGES)))
      else $error("Table full reported while space remains.");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != STS_OK) |-> (rsp_tdata == '0))
      else $error("Error word carries non-zero data.");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && chk_vld_ff) |-> ({1'b0, chk_pos_ff} < hi_ff))
      else $error("Row scan checked an edge beyond the row end.");

endmodule

@@ design/ceat_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// Width and depth are parameters; it has no dependencies.
`timescale 1ns / 1ps

module ceat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
